FILE: rtl/sog_pkg.sv
`default_nettype none
package sog_pkg;

  localparam int GridW = 20;
  localparam int GridH = 20;
  localparam int CordicN = 16;
  localparam logic [15:0] Kinv = 16'd39797;

  localparam logic [1:0] RegAngleStart = 2'd0;
  localparam logic [1:0] RegAngleStep  = 2'd1;
  localparam logic [1:0] RegRangeFloor = 2'd2;
  localparam logic [1:0] RegRangeCeil  = 2'd3;

  localparam logic ReqPose  = 1'b0;
  localparam logic ReqRange = 1'b1;
  localparam logic KindPose = 1'b0;
  localparam logic KindRow  = 1'b1;

  // Work item handed from the front to the back part.
  typedef struct packed {
    logic        is_pose;
    logic        hit;
    logic        scan_end;
    logic [15:0] range;
    logic [15:0] angle;
    logic [15:0] turns;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } work_t;

  function automatic logic [23:0] atan_lut(input logic [3:0] i);
    logic [23:0] v;
    case (i)
      4'd0: v = 24'd2097152;  4'd1: v = 24'd1238021;
      4'd2: v = 24'd654136;   4'd3: v = 24'd332050;
      4'd4: v = 24'd166669;   4'd5: v = 24'd83416;
      4'd6: v = 24'd41718;    4'd7: v = 24'd20860;
      4'd8: v = 24'd10430;    4'd9: v = 24'd5215;
      4'd10: v = 24'd2608;    4'd11: v = 24'd1304;
      4'd12: v = 24'd652;     4'd13: v = 24'd326;
      4'd14: v = 24'd163;     4'd15: v = 24'd81;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sog_if.sv
`default_nettype none
interface sog_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [15:0] pose_x;
  logic [15:0] pose_y;
  logic [15:0] yaw_in;
  logic [15:0] range_value;
  logic        scan_end;
  modport source (output valid, req_type, pose_x, pose_y, yaw_in, range_value, scan_end,
                  input ready);
  modport sink (input valid, req_type, pose_x, pose_y, yaw_in, range_value, scan_end,
                output ready);
endinterface

interface sog_res_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [4:0]  row_index;
  logic [19:0] row_cells;
  logic [15:0] turn_total;
  logic        run_last;
  modport source (output valid, result_kind, row_index, row_cells, turn_total, run_last,
                  input ready);
  modport sink (input valid, result_kind, row_index, row_cells, turn_total, run_last,
                output ready);
endinterface

interface sog_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/sog_front.sv
`default_nettype none
module sog_front (
  input  wire logic           clk,
  input  wire logic           rst,
  sog_req_if.sink             req,
  sog_cfg_if.sink             cfg,
  output sog_pkg::work_t      work,
  output logic                work_valid,
  input  wire logic           work_ready
);
  logic [15:0] angle_start, angle_step, range_floor, range_ceiling;
  logic [15:0] beam_index, last_yaw;
  logic signed [15:0] turn_count, turn_next;
  logic signed [15:0] robot_x, robot_y;
  logic [31:0] beam_prod;
  logic [16:0] dn, up;
  logic        fire;

  assign cfg.ready  = 1'b1;
  assign req.ready  = work_ready;
  assign work_valid = req.valid;
  assign fire       = req.valid & work_ready;
  assign beam_prod  = beam_index * angle_step;
  assign dn = {1'b0, last_yaw} - {1'b0, req.yaw_in};
  assign up = {1'b0, req.yaw_in} - {1'b0, last_yaw};

  always_comb begin
    turn_next = turn_count;
    if (!dn[16] && dn > 17'd32768) begin
      if (turn_count != 16'sh7fff) turn_next = turn_count + 16'sd1;
    end else if (!up[16] && up > 17'd32768) begin
      if (turn_count != 16'sh8000) turn_next = turn_count - 16'sd1;
    end
  end

  // Carry the position with each item so queued samples keep their own pose.
  always_comb begin
    work.is_pose  = (req.req_type == sog_pkg::ReqPose);
    work.hit      = (req.range_value >= range_floor) && (req.range_value <= range_ceiling);
    work.scan_end = req.scan_end;
    work.range    = req.range_value;
    work.angle    = angle_start + beam_prod[15:0] + last_yaw;
    work.turns    = work.is_pose ? turn_next : turn_count;
    work.pos_x    = robot_x;
    work.pos_y    = robot_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_start <= 16'd0; angle_step <= 16'd182;
      range_floor <= 16'd0; range_ceiling <= 16'hffff;
      beam_index <= 16'd0; last_yaw <= 16'd0; turn_count <= 16'sd0;
      robot_x <= 16'sd0; robot_y <= 16'sd0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          sog_pkg::RegAngleStart: angle_start   <= cfg.data;
          sog_pkg::RegAngleStep:  angle_step    <= cfg.data;
          sog_pkg::RegRangeFloor: range_floor   <= cfg.data;
          sog_pkg::RegRangeCeil:  range_ceiling <= cfg.data;
          default: ;
        endcase
      end
      if (fire) begin
        if (work.is_pose) begin
          robot_x <= req.pose_x; robot_y <= req.pose_y;
          last_yaw <= req.yaw_in; turn_count <= turn_next;
        end else begin
          beam_index <= req.scan_end ? 16'd0 : beam_index + 16'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sog_fifo.sv
`default_nettype none
module sog_fifo (
  input  wire logic      clk,
  input  wire logic      rst,
  input  sog_pkg::work_t in_item,
  input  wire logic      in_valid,
  output logic           in_ready,
  output sog_pkg::work_t out_item,
  output logic           out_valid,
  input  wire logic      out_ready
);
  sog_pkg::work_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= in_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (out_valid && out_ready) rp <= ~rp;
      cnt <= cnt + 2'((in_valid && in_ready) ? 1 : 0) - 2'((out_valid && out_ready) ? 1 : 0);
    end
  end
endmodule
`default_nettype wire

FILE: rtl/sog_back.sv
`default_nettype none
module sog_back #(
  parameter int GRID_W = sog_pkg::GridW,
  parameter int GRID_H = sog_pkg::GridH
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  sog_pkg::work_t     work,
  input  wire logic          work_valid,
  output logic               work_ready,
  sog_res_if.source          res
);
  localparam int RW = (GRID_H > 1) ? $clog2(GRID_H) : 1;
  localparam int CW = (GRID_W > 1) ? $clog2(GRID_W) : 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_MUL = 5'b00010, S_ROT = 5'b00100,
    S_MARK = 5'b01000, S_EMIT = 5'b10000
  } state_t;

  state_t state;
  sog_pkg::work_t cur;
  logic [GRID_W-1:0] grid [GRID_H];
  logic signed [42:0] x, y, z;
  logic [3:0] it;
  logic [RW-1:0] row;
  logic signed [16:0] a;
  logic signed [42:0] dx, dy, px, py, cx, cy;
  logic signed [42:0] zs;
  logic [31:0] prod;
  logic neg;

  assign work_ready = (state == S_IDLE) && !res.valid;

  // Pre-rotate angles beyond a quarter turn by a half turn.
  always_comb begin
    a = 17'(signed'(work.angle));
    neg = 1'b0;
    if (a > 17'sd16384) begin neg = 1'b1; a = a - 17'sd32768; end
    else if (a < -17'sd16384) begin neg = 1'b1; a = a + 17'sd32768; end
  end

  assign prod = cur.range * sog_pkg::Kinv;
  assign dx = y >>> it;
  assign dy = x >>> it;
  assign zs = 43'(signed'({1'b0, sog_pkg::atan_lut(it)}));
  assign px = (43'($signed(cur.pos_x)) <<< 16) + x + (43'(GRID_W / 2) <<< 24);
  assign py = (43'($signed(cur.pos_y)) <<< 16) + y + (43'(GRID_H / 2) <<< 24);
  assign cx = px >>> 24;
  assign cy = py >>> 24;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; res.valid <= 1'b0;
      for (int k = 0; k < GRID_H; k++) grid[k] <= '0;
    end else begin
      if (res.valid && res.ready && state != S_EMIT) res.valid <= 1'b0;
      case (state)
        S_IDLE: if (work_valid && work_ready) begin
          cur <= work;
          z <= 43'(a) <<< 8;
          y <= '0;
          it <= 4'd0;
          row <= '0;
          x <= neg ? 43'sd1 : 43'sd0;
          if (work.is_pose) begin
            res.valid <= 1'b1;
            res.result_kind <= sog_pkg::KindPose;
            res.row_index <= 5'd0; res.row_cells <= 20'd0;
            res.turn_total <= work.turns; res.run_last <= 1'b1;
          end else if (work.hit) state <= S_MUL;
          else if (work.scan_end) state <= S_EMIT;
        end
        S_MUL: begin
          x <= (x == 43'sd1) ? -43'(signed'({1'b0, prod})) : 43'(signed'({1'b0, prod}));
          state <= S_ROT;
        end
        S_ROT: begin
          if (!z[42]) begin x <= x - dx; y <= y + dy; z <= z - zs; end
          else begin x <= x + dx; y <= y - dy; z <= z + zs; end
          it <= it + 4'd1;
          if (it == 4'(sog_pkg::CordicN - 1)) state <= S_MARK;
        end
        S_MARK: begin
          if (cx >= 0 && cx < GRID_W && cy >= 0 && cy < GRID_H)
            grid[cy[RW-1:0]][cx[CW-1:0]] <= 1'b1;
          state <= cur.scan_end ? S_EMIT : S_IDLE;
        end
        S_EMIT: if (!res.valid || res.ready) begin
          res.valid <= 1'b1;
          res.result_kind <= sog_pkg::KindRow;
          res.row_index <= 5'(row);
          res.row_cells <= 20'(grid[row]);
          res.turn_total <= cur.turns;
          res.run_last <= (row == RW'(GRID_H - 1));
          grid[row] <= '0;
          if (row == RW'(GRID_H - 1)) state <= S_IDLE;
          else row <= row + RW'(1);
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/scan_to_occupancy_grid.sv
`default_nettype none
// Scan-to-occupancy-grid marker. Pose items latch position and yaw, unwrap the
// yaw into a saturating turn count and answer with one acknowledgement item.
// Range samples in the window are rotated by a 16-step CORDIC (one step per
// cycle) and mark one cell of a GRID_W x GRID_H map of 1 m cells; the sample
// flagged as scan end sends every row out and clears it. The front part
// classifies items and a two-entry queue decouples it from the back part.
// Flow: the back part takes no new item while its acknowledgement or a row is
// still waiting to be taken, nor while it works on an in-window sample (accept,
// gain multiply, 16 CORDIC steps, mark); on scan end it sends the rows out in
// order, each one as the previous one is taken.
module scan_to_occupancy_grid #(
  parameter int GRID_W = sog_pkg::GridW,
  parameter int GRID_H = sog_pkg::GridH
) (
  input wire logic clk,
  input wire logic rst,
  sog_req_if.sink   req,
  sog_res_if.source res,
  sog_cfg_if.sink   cfg
);
  sog_pkg::work_t f_work, b_work;
  logic f_valid, f_ready, b_valid, b_ready;

  // Front: classify the item and hold pose state.
  sog_front u_front (
    .clk, .rst, .req, .cfg,
    .work(f_work), .work_valid(f_valid), .work_ready(f_ready)
  );

  sog_fifo u_fifo (
    .clk, .rst,
    .in_item(f_work), .in_valid(f_valid), .in_ready(f_ready),
    .out_item(b_work), .out_valid(b_valid), .out_ready(b_ready)
  );

  // Back: rotate, mark and emit rows. Each sample carries the position that
  // held when it was accepted, so a later pose item cannot disturb it.
  sog_back #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_back (
    .clk, .rst,
    .work(b_work), .work_valid(b_valid), .work_ready(b_ready),
    .res
  );
endmodule
`default_nettype wire

FILE: test/tb.sv
`default_nettype none
module tb;

  // One request as handed to the block, and one result as expected back.
  typedef struct {
    logic        kind;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] yaw;
    logic [15:0] rng;
    logic        last_beam;
  } req_item_t;

  typedef struct {
    logic        kind;
    logic [4:0]  row;
    logic [19:0] cells;
    logic [15:0] turns;
    logic        last;
  } res_item_t;

  localparam int DrainCycles = 64;
  localparam int StallLimit  = 2000;
  localparam int HoldCycles  = 400;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sog_req_if req_if ();
  sog_res_if res_if ();
  sog_cfg_if cfg_if ();

  scan_to_occupancy_grid dut (
    .clk(clk),
    .rst(rst),
    .req(req_if.sink),
    .res(res_if.source),
    .cfg(cfg_if.sink)
  );

  // Mirror of the block's state and registers.
  logic [15:0] m_angle_start, m_angle_step, m_range_floor, m_range_ceil;
  logic [19:0] m_grid [sog_pkg::GridH];
  logic [15:0] m_beam;
  logic signed [15:0] m_rx, m_ry;
  logic [15:0] m_last_yaw;
  int          m_turns;

  req_item_t pending_reqs[$];
  res_item_t expected_results[$];
  int  error_count = 0;
  int  accepted_reqs = 0;
  bit  no_idle = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  const longint atan_q24 [sog_pkg::CordicN] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81};

  initial begin
    forever #5 clk = ~clk;
  end

  // Gain-compensated CORDIC rotation of a range along a binary angle.
  task automatic beam_rotate(input logic [15:0] r, input logic [15:0] ang,
                             output longint ox, output longint oy);
    longint x, y, z, dx, dy;
    int a;
    a = int'($signed(ang));
    x = longint'(r) * 39797;
    y = 0;
    // fold angles past a quarter turn back by half a turn
    if (a > 16384) begin
      x = -x;
      a -= 32768;
    end else if (a < -16384) begin
      x = -x;
      a += 32768;
    end
    z = longint'(a) * 256;
    for (int i = 0; i < sog_pkg::CordicN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q24[i];
      end else begin
        x += dx; y -= dy; z += atan_q24[i];
      end
    end
    ox = x;
    oy = y;
  endtask

  // Work out what one accepted request produces and queue it.
  task automatic predict_grid(input req_item_t it);
    res_item_t r;
    logic [15:0] turns_now, ang;
    longint dx, dy, px, py, cx, cy;
    int yaw_new, yaw_old;
    turns_now = m_turns[15:0];
    if (it.kind == sog_pkg::ReqPose) begin
      yaw_new = it.yaw;
      yaw_old = m_last_yaw;
      m_rx = it.px;
      m_ry = it.py;
      // unwrap: a jump of more than half a turn counts one turn, saturating
      if (yaw_old - yaw_new > 32768) begin
        if (m_turns < 32767) m_turns++;
      end else if (yaw_new - yaw_old > 32768) begin
        if (m_turns > -32768) m_turns--;
      end
      m_last_yaw = it.yaw;
      r = '{sog_pkg::KindPose, 5'd0, 20'd0, m_turns[15:0], 1'b1};
      expected_results.push_back(r);
    end else begin
      if (it.rng >= m_range_floor && it.rng <= m_range_ceil) begin
        ang = m_angle_start + m_beam * m_angle_step + m_last_yaw;
        beam_rotate(it.rng, ang, dx, dy);
        px = longint'(m_rx) * 65536 + dx + (longint'(sog_pkg::GridW / 2) << 24);
        py = longint'(m_ry) * 65536 + dy + (longint'(sog_pkg::GridH / 2) << 24);
        cx = px >>> 24;
        cy = py >>> 24;
        // points off the map are dropped
        if (cx >= 0 && cx < sog_pkg::GridW && cy >= 0 && cy < sog_pkg::GridH)
          m_grid[cy][cx] = 1'b1;
      end
      m_beam = m_beam + 16'd1;
      if (it.last_beam) begin
        for (int k = 0; k < sog_pkg::GridH; k++) begin
          r = '{sog_pkg::KindRow, k[4:0], m_grid[k], turns_now, k == sog_pkg::GridH - 1};
          expected_results.push_back(r);
          m_grid[k] = '0;
        end
        m_beam = '0;
      end
    end
  endtask

  // Driver: advance to the next pending item once the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_if.ready) begin
      if (req_if.valid) begin
        predict_grid('{req_if.req_type, req_if.pose_x, req_if.pose_y, req_if.yaw_in,
                       req_if.range_value, req_if.scan_end});
        accepted_reqs++;
      end
      if (pending_reqs.size() > 0 && (no_idle || $urandom_range(0, 99) >= 8)) begin
        req_if.valid       <= 1'b1;
        req_if.req_type    <= pending_reqs[0].kind;
        req_if.pose_x      <= pending_reqs[0].px;
        req_if.pose_y      <= pending_reqs[0].py;
        req_if.yaw_in      <= pending_reqs[0].yaw;
        req_if.range_value <= pending_reqs[0].rng;
        req_if.scan_end    <= pending_reqs[0].last_beam;
        void'(pending_reqs.pop_front());
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: compare each result with the oldest expectation; stall at random.
  always @(posedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d row %0d", res_if.result_kind, res_if.row_index);
          error_count++;
        end else begin
          if (res_if.result_kind !== expected_results[0].kind) begin
            $error("result_kind: expected %0d, got %0d", expected_results[0].kind,
                   res_if.result_kind);
            error_count++;
          end
          if (res_if.row_index !== expected_results[0].row) begin
            $error("row_index: expected %0d, got %0d", expected_results[0].row,
                   res_if.row_index);
            error_count++;
          end
          if (res_if.row_cells !== expected_results[0].cells) begin
            $error("row_cells: expected %h, got %h", expected_results[0].cells,
                   res_if.row_cells);
            error_count++;
          end
          if (res_if.turn_total !== expected_results[0].turns) begin
            $error("turn_total: expected %0d, got %0d", $signed(expected_results[0].turns),
                   $signed(res_if.turn_total));
            error_count++;
          end
          if (res_if.run_last !== expected_results[0].last) begin
            $error("run_last: expected %0d, got %0d", expected_results[0].last,
                   res_if.run_last);
            error_count++;
          end
          void'(expected_results.pop_front());
        end
      end
      // hold off once for a long stretch so the block backs up onto its input
      if (!hold_done && accepted_reqs >= 150) begin
        hold_done <= 1'b1;
        hold_left <= HoldCycles;
        res_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= no_idle || $urandom_range(0, 99) >= 8;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    cfg_if.valid <= 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      sog_pkg::RegAngleStart: m_angle_start = val;
      sog_pkg::RegAngleStep:  m_angle_step  = val;
      sog_pkg::RegRangeFloor: m_range_floor = val;
      sog_pkg::RegRangeCeil:  m_range_ceil  = val;
      default: ;
    endcase
  endtask

  task automatic set_window(input logic [15:0] a0, input logic [15:0] step,
                            input logic [15:0] lo, input logic [15:0] hi);
    write_reg(sog_pkg::RegAngleStart, a0);
    write_reg(sog_pkg::RegAngleStep, step);
    write_reg(sog_pkg::RegRangeFloor, lo);
    write_reg(sog_pkg::RegRangeCeil, hi);
    cfg_if.valid <= 1'b0;
  endtask

  // Hold until the block has drained, then let any sample still in flight settle.
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_if.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic void add_pose(input logic [15:0] x, input logic [15:0] y,
                                   input logic [15:0] yaw);
    pending_reqs.push_back('{sog_pkg::ReqPose, x, y, yaw, 16'($urandom), 1'($urandom)});
  endfunction

  function automatic void add_beam(input logic [15:0] r, input logic last_beam);
    pending_reqs.push_back('{sog_pkg::ReqRange, 16'($urandom), 16'($urandom),
                             16'($urandom), r, last_beam});
  endfunction

  function automatic logic [15:0] near_coord();
    if ($urandom_range(0, 99) < 85) return 16'($signed($urandom_range(0, 5120)) - 2560);
    return 16'($urandom);
  endfunction

  // Mostly whole scans from a fresh pose, some stray samples and poses.
  function automatic void add_random(input int count);
    int n, len;
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 9) < 8) begin
        add_pose(near_coord(), near_coord(), 16'($urandom));
        len = $urandom_range(1, 10);
        for (int b = 0; b < len; b++)
          add_beam(($urandom_range(0, 99) < 80) ? 16'($urandom_range(0, 3600))
                                                : 16'($urandom), b == len - 1);
        n += len + 1;
      end else if ($urandom_range(0, 1) == 1) begin
        add_beam(16'($urandom_range(0, 3600)), 1'b0);
        n++;
      end else begin
        add_pose(16'($urandom), 16'($urandom), 16'($urandom));
        n++;
      end
    end
  endfunction

  initial begin
    m_angle_start = '0;
    m_angle_step  = 16'd182;
    m_range_floor = '0;
    m_range_ceil  = 16'hffff;
    foreach (m_grid[k]) m_grid[k] = '0;
    m_beam = '0;
    m_rx = '0;
    m_ry = '0;
    m_last_yaw = '0;
    m_turns = 0;
    req_if.req_type = 1'b0;
    req_if.pose_x = '0;
    req_if.pose_y = '0;
    req_if.yaw_in = '0;
    req_if.range_value = '0;
    req_if.scan_end = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = sog_pkg::RegAngleStart;
    cfg_if.data = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, field extremes and the yaw unwrap corners.
    add_beam(16'd0, 1'b1);                        // scan end as the only sample
    add_pose(16'h8000, 16'h7fff, 16'd0);
    add_beam(16'hffff, 1'b0);
    add_beam(16'd0, 1'b1);
    add_pose(16'd0, 16'd0, 16'd32768);            // exactly half a turn: no count
    add_pose(16'd0, 16'd0, 16'd0);
    add_pose(16'd0, 16'd0, 16'd65535);            // down a turn
    add_pose(16'd0, 16'd0, 16'd0);                // up a turn
    add_pose(16'd256, 16'hff00, 16'd0);
    add_beam(16'd1280, 1'b0);
    add_beam(16'd512, 1'b0);
    add_beam(16'd2304, 1'b0);                     // lands just inside the map edge
    add_beam(16'd2559, 1'b0);
    add_beam(16'd700, 1'b1);
    add_pose(16'h7fff, 16'h8000, 16'hffff);       // robot far off the map
    add_beam(16'd100, 1'b1);
    add_pose(16'h0000, 16'h0000, 16'd16384);
    add_beam(16'd1000, 1'b1);
    add_random(80);
    wait_drained();

    // Narrow window with wide beam spacing; skipped samples still advance the beam.
    set_window(16'd0, 16'd4096, 16'd256, 16'd3000);
    add_pose(16'd0, 16'd0, 16'd0);
    add_beam(16'd255, 1'b0);
    add_beam(16'd256, 1'b0);
    add_beam(16'd3000, 1'b0);
    add_beam(16'd3001, 1'b1);
    add_random(90);
    wait_drained();

    // Largest start and step, full window; run this one without idling.
    set_window(16'hffff, 16'hffff, 16'd0, 16'hffff);
    no_idle = 1'b1;
    add_random(95);
    wait_drained();
    no_idle = 1'b0;

    // Floor above ceiling: every sample skipped, rows stay clear.
    set_window(16'd16384, 16'd0, 16'd5000, 16'd100);
    add_random(40);
    wait_drained();

    // Random settings with a usable window.
    for (int p = 0; p < 2; p++) begin
      set_window(16'($urandom), 16'($urandom), 16'($urandom_range(0, 800)),
                 16'($urandom_range(1500, 65535)));
      add_random(75);
      wait_drained();
    end

    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
